>>> rtl/dwa_pkg.sv
`default_nettype none

package dwa_pkg;

	localparam int STATE_W  = 4;
	localparam int SYMBOL_W = 4;
	localparam int MASK_W   = 16;
	localparam int CFG_W    = 16;

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_WRITE = 2'd0;
	localparam opcode_t OP_FEED  = 2'd1;
	localparam opcode_t OP_END   = 2'd2;

	typedef logic [1:0] verdict_t;
	localparam verdict_t V_ACCEPTED = 2'd0;
	localparam verdict_t V_REJECTED = 2'd1;
	localparam verdict_t V_BLOCKED  = 2'd2;
	localparam verdict_t V_INVALID  = 2'd3;

	typedef logic [1:0] reg_index_t;
	localparam reg_index_t REG_INITIAL  = 2'd0;
	localparam reg_index_t REG_FINAL    = 2'd1;
	localparam reg_index_t REG_ALPHABET = 2'd2;

	typedef struct packed {
		logic                blocked;
		logic [STATE_W-1:0]  target;
	} entry_t;

	typedef struct packed {
		logic   wr;
		logic   rd;
		entry_t wdata;
	} tbl_req_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} tbl_rsp_t;

endpackage

`default_nettype wire

>>> rtl/dwa_table.sv
`default_nettype none

module dwa_table #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dwa_pkg::tbl_req_t req,
	input  wire logic [AW-1:0]     addr,
	output      dwa_pkg::tbl_rsp_t rsp
);
	import dwa_pkg::*;

	entry_t mem [DEPTH];
	logic   vld_q [DEPTH];
	entry_t rd_s1;
	logic   rd_vld_s1;

	// single-port store: one transaction either writes or reads an entry
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[addr] <= req.wdata;
		end
		if (req.rd) begin
			rd_s1 <= mem[addr];
		end
	end

	// valid bits mark written entries; reset marks every entry absent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				vld_q[i] <= 1'b0;
			end
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.wr) begin
				vld_q[addr] <= 1'b1;
			end
			if (req.rd) begin
				rd_vld_s1 <= vld_q[addr];
			end
		end
	end

	assign rsp.valid = rd_vld_s1;
	assign rsp.entry = rd_s1;

endmodule

`default_nettype wire

>>> rtl/dwa_skid.sv
`default_nettype none

module dwa_skid (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire dwa_pkg::verdict_t push_verdict,
	output      logic              full,
	output      logic              result_valid,
	input  wire logic              result_ready,
	output      dwa_pkg::verdict_t verdict
);
	import dwa_pkg::*;

	logic     out_v_q;
	verdict_t out_d_q;
	logic     sk_v_q;
	verdict_t sk_d_q;
	logic     pop;

	assign pop = out_v_q && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else begin
			priority if (!out_v_q) begin
				out_v_q <= push;
			end else if (pop) begin
				// advance the skid entry, or refill straight from the new push
				if (sk_v_q) begin
					sk_v_q <= push;
				end else begin
					out_v_q <= push;
				end
			end else if (push) begin
				sk_v_q <= 1'b1;
			end else begin
				// hold both slots
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (!out_v_q) begin
			out_d_q <= push_verdict;
		end else if (pop) begin
			if (sk_v_q) begin
				out_d_q <= sk_d_q;
				sk_d_q  <= push_verdict;
			end else begin
				out_d_q <= push_verdict;
			end
		end else if (push) begin
			sk_d_q <= push_verdict;
		end else begin
			// hold both slots
		end
	end

	assign full         = sk_v_q;
	assign result_valid = out_v_q;
	assign verdict      = out_d_q;

endmodule

`default_nettype wire

>>> rtl/dfa_word_acceptor_core.sv
// Programmable DFA word acceptor.
// Item channel (item_valid/item_ready) carries one command per transaction:
//   write a table entry, feed one symbol, or end the word.
// Result channel (result_valid/result_ready) carries one verdict for every
// end-of-word transaction and nothing for the other commands.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) set the initial state,
// the accepting-state mask and the alphabet mask; they take effect at once.
// Throughput: one command per cycle. A fed symbol reads the transition table
// (one single-port RAM with a registered read); the entry read is resolved in the
// following cycle and steers the next lookup address, so symbols stream
// back to back with no bubble.
// A verdict is registered into the output buffer as its end-of-word command is taken.
// Stall: a two-deep output buffer holds verdicts; item_ready falls only when
// two verdicts wait and the receiver holds result_ready low.
// Reset: registers take their reset values and every table entry reads as
// absent straight away; no clearing pass, item_ready is high as soon as reset
// is released.
`default_nettype none

module dfa_word_acceptor_core #(
	parameter int NUM_STATES  = 16,
	parameter int NUM_SYMBOLS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output      logic                          item_ready,
	input  wire dwa_pkg::opcode_t              opcode,
	input  wire logic [dwa_pkg::STATE_W-1:0]   from_state,
	input  wire logic [dwa_pkg::SYMBOL_W-1:0]  symbol,
	input  wire logic [dwa_pkg::STATE_W-1:0]   target_state,
	input  wire logic                          target_blocked,
	output      logic                          result_valid,
	input  wire logic                          result_ready,
	output      dwa_pkg::verdict_t             verdict,
	input  wire logic                          cfg_we,
	input  wire dwa_pkg::reg_index_t           cfg_index,
	input  wire logic [dwa_pkg::CFG_W-1:0]     cfg_wdata
);
	import dwa_pkg::*;

	// states and symbols beyond the field range can never be addressed
	localparam int NS_EFF = (NUM_STATES < (1 << STATE_W)) ? NUM_STATES : (1 << STATE_W);
	localparam int NY_EFF = (NUM_SYMBOLS < (1 << SYMBOL_W)) ? NUM_SYMBOLS : (1 << SYMBOL_W);
	localparam int DEPTH  = NS_EFF * NY_EFF;
	localparam int AW     = $clog2(DEPTH);
	localparam logic [STATE_W:0]  NS_LIM = (STATE_W + 1)'(NS_EFF);
	localparam logic [SYMBOL_W:0] NY_LIM = (SYMBOL_W + 1)'(NY_EFF);

	logic [STATE_W-1:0] init_q;
	logic [MASK_W-1:0]  final_q;
	logic [MASK_W-1:0]  alpha_q;

	logic [STATE_W-1:0] cur_q;
	logic               in_word_q;
	logic               blk_q;
	logic               inv_q;
	logic               look_s1;

	tbl_req_t           req;
	tbl_rsp_t           rsp;
	logic [AW-1:0]      tbl_addr;
	logic [STATE_W-1:0] addr_state;

	logic               acc;
	logic               is_wr;
	logic               is_feed;
	logic               is_end;
	logic               eff_hit;
	logic [STATE_W-1:0] eff_cur;
	logic               eff_blk;
	logic [STATE_W-1:0] b_cur;
	logic               b_blk;
	logic               b_inv;
	logic               st_ok;
	logic               from_ok;
	logic               sym_ok;
	logic               sym_in;
	logic               feed_go;
	verdict_t           v_code;
	logic               skid_full;

	assign acc     = item_valid && item_ready;
	assign is_wr   = acc && (opcode == OP_WRITE);
	assign is_feed = acc && (opcode == OP_FEED);
	assign is_end  = acc && (opcode == OP_END);

	always_comb begin
		// resolve the lookup issued last cycle against the RAM output
		eff_hit = rsp.valid && !rsp.entry.blocked;
		eff_cur = (look_s1 && eff_hit) ? rsp.entry.target : cur_q;
		eff_blk = blk_q || (look_s1 && !eff_hit);

		// a word starts from the initial state as it stands now
		b_cur = in_word_q ? eff_cur : init_q;
		b_blk = in_word_q && eff_blk;
		b_inv = in_word_q && inv_q;

		st_ok   = {1'b0, b_cur} < NS_LIM;
		from_ok = {1'b0, from_state} < NS_LIM;
		sym_ok  = {1'b0, symbol} < NY_LIM;
		sym_in  = alpha_q[symbol];
		feed_go = sym_in && !b_blk && st_ok && sym_ok;

		req.wr    = is_wr && from_ok && sym_ok;
		req.rd    = is_feed && feed_go;
		req.wdata = '{blocked: target_blocked, target: target_state};

		addr_state = (opcode == OP_WRITE) ? from_state : b_cur;
		tbl_addr   = AW'(int'(addr_state) * NY_EFF + int'(symbol));

		priority if (b_inv) begin
			v_code = V_INVALID;
		end else if (b_blk) begin
			v_code = V_BLOCKED;
		end else if (final_q[b_cur]) begin
			v_code = V_ACCEPTED;
		end else begin
			v_code = V_REJECTED;
		end
	end

	// a write lands at its edge, so a lookup in the next cycle already sees it
	dwa_table #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.addr   (tbl_addr),
		.rsp    (rsp)
	);

	dwa_skid u_skid (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (is_end),
		.push_verdict (v_code),
		.full         (skid_full),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.verdict      (verdict)
	);

	assign item_ready = !skid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= '0;
			final_q <= '0;
			alpha_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INITIAL:  init_q  <= cfg_wdata[STATE_W-1:0];
				REG_FINAL:    final_q <= cfg_wdata[MASK_W-1:0];
				REG_ALPHABET: alpha_q <= cfg_wdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			in_word_q <= 1'b0;
			blk_q     <= 1'b0;
			inv_q     <= 1'b0;
			look_s1   <= 1'b0;
		end else begin
			// commit any resolved lookup
			cur_q   <= eff_cur;
			blk_q   <= eff_blk;
			look_s1 <= 1'b0;
			if (acc) begin
				unique case (opcode)
					OP_FEED: begin
						in_word_q <= 1'b1;
						cur_q     <= b_cur;
						inv_q     <= b_inv || !sym_in;
						look_s1   <= feed_go;
						blk_q     <= b_blk || (sym_in && !b_blk && !(st_ok && sym_ok));
					end
					OP_END: begin
						cur_q     <= init_q;
						in_word_q <= 1'b0;
						blk_q     <= 1'b0;
						inv_q     <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

`ifndef SYNTH
	a_lookup_in_word: assert property (@(posedge clk) disable iff (!arst_n)
		look_s1 |-> in_word_q)
		else $error("lookup pending outside a word");

	a_end_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		is_end |=> result_valid)
		else $error("end of word produced no verdict");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid)
		else $error("item channel stalled with no verdict waiting");
`endif

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import dwa_pkg::*;

	localparam int TABLE_DEPTH   = 1 << (STATE_W + SYMBOL_W);
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 240;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int IDLE_PCT      = 22;

	localparam opcode_t    OP_UNUSED  = 2'd3;
	localparam reg_index_t REG_UNUSED = 2'd3;

	typedef struct packed {
		logic   present;
		entry_t entry;
	} slot_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                item_valid;
	logic                item_ready;
	opcode_t             opcode;
	logic [STATE_W-1:0]  from_state;
	logic [SYMBOL_W-1:0] symbol;
	logic [STATE_W-1:0]  target_state;
	logic                target_blocked;
	logic                result_valid;
	logic                result_ready;
	verdict_t            verdict;
	logic                cfg_we;
	reg_index_t          cfg_index;
	logic [CFG_W-1:0]    cfg_wdata;

	// automaton mirror
	logic [STATE_W-1:0]  init_state_reg;
	logic [MASK_W-1:0]   accept_mask;
	logic [MASK_W-1:0]   alphabet_reg;
	logic [STATE_W-1:0]  dfa_state;
	logic                word_open;
	logic                blocked_hit;
	logic                invalid_hit;
	slot_t               trans_table [TABLE_DEPTH];
	verdict_t            expected_verdicts [$];

	int unsigned items_sent;
	int unsigned verdicts_seen;
	int unsigned verdict_count [4];
	int unsigned err_count;
	int unsigned cycle_count;
	int unsigned config_phases;
	logic        idle_on;
	logic        hold_request;

	dfa_word_acceptor_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.opcode         (opcode),
		.from_state     (from_state),
		.symbol         (symbol),
		.target_state   (target_state),
		.target_blocked (target_blocked),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.verdict        (verdict),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [3:0] rand_nib();
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic void clear_mirror();
		init_state_reg = '0;
		accept_mask    = '0;
		alphabet_reg   = '1;
		dfa_state      = '0;
		word_open      = 1'b0;
		blocked_hit    = 1'b0;
		invalid_hit    = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			trans_table[i] = '0;
	endfunction

	function automatic void open_word();
		if (!word_open) begin
			dfa_state   = init_state_reg;
			blocked_hit = 1'b0;
			invalid_hit = 1'b0;
			word_open   = 1'b1;
		end
	endfunction

	// advance the mirror by one command; queue a verdict at end of word
	function automatic void dfa_step(opcode_t op, logic [3:0] from, logic [3:0] sym,
			logic [3:0] tgt, logic blk);
		slot_t    s;
		verdict_t v;
		case (op)
			OP_WRITE: begin
				s.present        = 1'b1;
				s.entry.blocked  = blk;
				s.entry.target   = tgt;
				trans_table[{from, sym}] = s;
			end
			OP_FEED: begin
				open_word();
				if (!alphabet_reg[sym]) begin
					invalid_hit = 1'b1;
				end else if (!blocked_hit) begin
					s = trans_table[{dfa_state, sym}];
					if (s.present && !s.entry.blocked)
						dfa_state = s.entry.target;
					else
						blocked_hit = 1'b1;
				end
			end
			OP_END: begin
				open_word();
				if (invalid_hit)
					v = V_INVALID;
				else if (blocked_hit)
					v = V_BLOCKED;
				else if (accept_mask[dfa_state])
					v = V_ACCEPTED;
				else
					v = V_REJECTED;
				expected_verdicts = {expected_verdicts, v};
				dfa_state   = init_state_reg;
				word_open   = 1'b0;
				blocked_hit = 1'b0;
				invalid_hit = 1'b0;
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor_block
		verdict_t want;
		if (!arst_n) begin
			clear_mirror();
		end else begin
			if (result_valid && result_ready) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch($sformatf("verdict %0d with none outstanding", verdict));
				end else begin
					want = expected_verdicts.pop_front();
					verdicts_seen++;
					verdict_count[want]++;
					if (verdict !== want)
						report_mismatch($sformatf("verdict %0d, expected %0d", verdict, want));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_INITIAL:  init_state_reg = cfg_wdata[STATE_W-1:0];
					REG_FINAL:    accept_mask    = cfg_wdata[MASK_W-1:0];
					REG_ALPHABET: alphabet_reg   = cfg_wdata[MASK_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && item_ready)
				dfa_step(opcode, from_state, symbol, target_state, target_blocked);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
				expected_verdicts.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stalls, or one long hold when asked
	initial begin
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				result_ready <= 1'b1;
			end else begin
				result_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	task automatic send_item(input opcode_t op, input logic [3:0] from, input logic [3:0] sym,
			input logic [3:0] tgt, input logic blk);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid     <= 1'b1;
		opcode         <= op;
		from_state     <= from;
		symbol         <= sym;
		target_state   <= tgt;
		target_blocked <= blk;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic feed_symbol(input logic [3:0] sym);
		send_item(OP_FEED, rand_nib(), sym, rand_nib(), 1'($urandom_range(0, 1)));
	endtask

	task automatic end_word();
		send_item(OP_END, rand_nib(), rand_nib(), rand_nib(), 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all three registers plus the unused index, then drop the enable
	task automatic set_config(input logic [3:0] init, input logic [15:0] fin,
			input logic [15:0] alpha);
		cfg_we    <= 1'b1;
		cfg_index <= REG_INITIAL;
		cfg_wdata <= {12'($urandom_range(0, 4095)), init};
		@(posedge clk);
		cfg_index <= REG_FINAL;
		cfg_wdata <= fin;
		@(posedge clk);
		cfg_index <= REG_ALPHABET;
		cfg_wdata <= alpha;
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_wdata <= 16'($urandom_range(0, 65535));
		@(posedge clk);
		cfg_we <= 1'b0;
		config_phases++;
	endtask

	task automatic send_noise();
		if ($urandom_range(0, 2) == 0)
			send_item(OP_UNUSED, rand_nib(), rand_nib(), rand_nib(), 1'($urandom_range(0, 1)));
		else
			send_item(OP_WRITE, rand_nib(), rand_nib(), rand_nib(), $urandom_range(99) < 15);
	endtask

	task automatic run_words(input int unsigned n_items, input int unsigned noise_pct);
		int unsigned stop_at;
		int unsigned len;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			len = $urandom_range(0, 7);
			repeat (len) begin
				if ($urandom_range(99) < noise_pct)
					send_noise();
				feed_symbol(rand_nib());
			end
			if ($urandom_range(99) < noise_pct)
				send_noise();
			end_word();
		end
	endtask

	task automatic test_reset_defaults();
		end_word();
		feed_symbol(4'd15);
		end_word();
		wait_drained();
	endtask

	task automatic test_directed_words();
		set_config(4'd15, 16'h8001, 16'h7FFF);
		send_item(OP_WRITE, 4'd15, 4'd0, 4'd0, 1'b0);
		send_item(OP_WRITE, 4'd0, 4'd3, 4'd5, 1'b0);
		send_item(OP_WRITE, 4'd0, 4'd2, 4'd15, 1'b1);
		end_word();
		feed_symbol(4'd0);
		end_word();
		feed_symbol(4'd0);
		feed_symbol(4'd3);
		end_word();
		// symbols after a blocked entry leave the state alone
		feed_symbol(4'd0);
		feed_symbol(4'd2);
		feed_symbol(4'd1);
		end_word();
		// invalid outranks blocked
		feed_symbol(4'd15);
		feed_symbol(4'd4);
		end_word();
		feed_symbol(4'd0);
		send_item(OP_UNUSED, 4'd15, 4'd15, 4'd15, 1'b1);
		end_word();
		// table write mid-word is seen by the next lookup
		feed_symbol(4'd0);
		send_item(OP_WRITE, 4'd0, 4'd4, 4'd15, 1'b0);
		feed_symbol(4'd4);
		end_word();
		wait_drained();
	endtask

	task automatic test_table_fill();
		set_config(4'd0, 16'($urandom_range(0, 65535)), 16'hFFFF);
		for (int st = 0; st < 16; st++)
			for (int sy = 0; sy < 16; sy++)
				send_item(OP_WRITE, 4'(st), 4'(sy), rand_nib(), $urandom_range(99) < 6);
		run_words(300, 5);
		wait_drained();
	endtask

	task automatic test_all_accepting_no_idle();
		set_config(4'd15, 16'hFFFF, 16'hFFFF);
		idle_on = 1'b0;
		run_words(250, 5);
		wait_drained();
		idle_on = 1'b1;
	endtask

	task automatic test_sparse_alphabet();
		set_config(rand_nib(), 16'h0000, ~(16'd1 << $urandom_range(0, 15)));
		run_words(250, 8);
		wait_drained();
	endtask

	task automatic test_empty_alphabet();
		set_config(rand_nib(), 16'($urandom_range(0, 65535)), 16'h0000);
		run_words(60, 5);
		wait_drained();
	endtask

	task automatic test_result_stall();
		set_config(rand_nib(), 16'($urandom_range(0, 65535)), 16'hFFFF);
		hold_request = 1'b1;
		repeat (30) begin
			if ($urandom_range(0, 1) == 1)
				feed_symbol(rand_nib());
			end_word();
		end
		wait_drained();
	endtask

	task automatic test_heavy_rewrites();
		set_config(rand_nib(), 16'($urandom_range(0, 65535)),
			16'hFFFF ^ (16'd1 << $urandom_range(0, 15)) ^ (16'd1 << $urandom_range(0, 15)));
		run_words(540, 20);
		wait_drained();
	endtask

	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		opcode         = OP_WRITE;
		from_state     = '0;
		symbol         = '0;
		target_state   = '0;
		target_blocked = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_INITIAL;
		cfg_wdata      = '0;
		idle_on        = 1'b1;
		hold_request   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_words();
		test_table_fill();
		test_result_stall();
		test_all_accepting_no_idle();
		test_sparse_alphabet();
		test_empty_alphabet();
		test_heavy_rewrites();
		wait_drained();

		$display("Covered %0d commands and %0d verdicts over %0d register settings",
			items_sent, verdicts_seen, config_phases);
		$display("Verdict mix: %0d accepted, %0d rejected, %0d blocked, %0d invalid",
			verdict_count[V_ACCEPTED], verdict_count[V_REJECTED],
			verdict_count[V_BLOCKED], verdict_count[V_INVALID]);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
